[design/kute_pkg.sv]
// Shared types, codes and constants of the key press to UTF-8 text entry block.
package kute_pkg;

    // Sizing
    localparam int STORE_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH = 2;                 // power of two, pointers wrap
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Key codes
    localparam logic [8:0] KC_BKSP     = 9'd259;
    localparam logic [8:0] KC_SPACE    = 9'd32;
    localparam logic [8:0] KC_QUOTE    = 9'd39;
    localparam logic [8:0] KC_COMMA    = 9'd44;
    localparam logic [8:0] KC_SLASH    = 9'd47;
    localparam logic [8:0] KC_DIGIT9   = 9'd57;
    localparam logic [8:0] KC_SEMI     = 9'd59;
    localparam logic [8:0] KC_EQUALS   = 9'd61;
    localparam logic [8:0] KC_A        = 9'd65;
    localparam logic [8:0] KC_E        = 9'd69;
    localparam logic [8:0] KC_I        = 9'd73;
    localparam logic [8:0] KC_N        = 9'd78;
    localparam logic [8:0] KC_O        = 9'd79;
    localparam logic [8:0] KC_U        = 9'd85;
    localparam logic [8:0] KC_Z        = 9'd90;
    localparam logic [8:0] KC_RBRACKET = 9'd93;
    localparam logic [8:0] KC_BACKTICK = 9'd96;

    // Byte values
    localparam logic [7:0] BYTE_QMARK    = 8'h3F;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;
    localparam logic [7:0] LEAD_C3       = 8'hC3;
    localparam logic [7:0] LEAD_C2       = 8'hC2;
    localparam logic [7:0] LEAD_CB       = 8'hCB;
    localparam logic [7:0] ACUTE_GLYPH   = 8'hB4;
    localparam logic [7:0] TILDE_GLYPH   = 8'h9C;
    localparam logic [7:0] INV_QMARK     = 8'hBF;
    localparam logic [7:0] SEC_A         = 8'h81;
    localparam logic [7:0] SEC_E         = 8'h89;
    localparam logic [7:0] SEC_I         = 8'h8D;
    localparam logic [7:0] SEC_O         = 8'h93;
    localparam logic [7:0] SEC_U         = 8'h9A;
    localparam logic [7:0] SEC_N         = 8'h91;
    localparam logic [1:0] TAIL_TAG      = 2'b10;

    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_PRINT = 2'd1,
        KIND_BKSP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ALT_NOTHING = 2'd0,
        ALT_ACUTE   = 2'd1,
        ALT_TILDE   = 2'd2,
        ALT_INVQ    = 2'd3
    } alt_op_t;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_ACUTE = 2'd1,
        ACC_TILDE = 2'd2
    } accent_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOOK = 2'd1,
        ST_OUT0 = 2'd2,
        ST_OUT1 = 2'd3
    } back_state_t;

    // Classified key press, front to back
    typedef struct packed {
        kind_t      kind;
        logic       alt;
        alt_op_t    alt_op;
        logic [7:0] plain_byte;
        logic [7:0] acute_byte;   // zero when the key takes no acute
        logic [7:0] tilde_byte;   // zero when the key takes no tilde
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Writes planned for one key press
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] addr0;
        logic [7:0] byte0;
        logic [7:0] addr1;
        logic [7:0] byte1;
    } plan_t;

    function automatic logic is_printable(input logic [8:0] k);
        logic res;
        res = (k == KC_SPACE) || (k == KC_QUOTE) || (k == KC_SEMI) ||
              (k == KC_EQUALS) || (k == KC_BACKTICK) ||
              ((k >= KC_COMMA) && (k <= KC_DIGIT9)) ||
              ((k >= KC_A) && (k <= KC_RBRACKET));
        return res;
    endfunction

endpackage

[design/kute_front.sv]
// Front end: accepts key press requests and classifies them into commands.
module kute_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,    // [8:0] key number, rest zero
    input  logic [1:0]          s_tuser,    // [0] shift_held, [1] alt_held
    input  kute_pkg::q_status_t q_status,
    output logic                q_push,
    output kute_pkg::cmd_t      q_cmd
);

    logic [8:0] key;
    logic       shift;
    logic       alt;
    logic [7:0] acute_raw;
    logic [7:0] adj;

    assign key   = s_tdata[8:0];
    assign shift = s_tuser[0];
    assign alt   = s_tuser[1];

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && !q_status.full;

    // Classification of the key
    always_comb begin
        adj = shift ? 8'd0 : kute_pkg::CASE_OFFSET;
        acute_raw = 8'd0;
        if (key == kute_pkg::KC_A) acute_raw = kute_pkg::SEC_A;
        else if (key == kute_pkg::KC_E) acute_raw = kute_pkg::SEC_E;
        else if (key == kute_pkg::KC_I) acute_raw = kute_pkg::SEC_I;
        else if (key == kute_pkg::KC_O) acute_raw = kute_pkg::SEC_O;
        else if (key == kute_pkg::KC_U) acute_raw = kute_pkg::SEC_U;

        if (kute_pkg::is_printable(key)) q_cmd.kind = kute_pkg::KIND_PRINT;
        else if (key == kute_pkg::KC_BKSP) q_cmd.kind = kute_pkg::KIND_BKSP;
        else q_cmd.kind = kute_pkg::KIND_NOP;

        q_cmd.alt = alt;
        if (key == kute_pkg::KC_E) q_cmd.alt_op = kute_pkg::ALT_ACUTE;
        else if (key == kute_pkg::KC_N) q_cmd.alt_op = kute_pkg::ALT_TILDE;
        else if (key == kute_pkg::KC_SLASH && shift) q_cmd.alt_op = kute_pkg::ALT_INVQ;
        else q_cmd.alt_op = kute_pkg::ALT_NOTHING;

        // Plain ASCII: shifted slash is '?', letters lowered without shift
        if (shift && key == kute_pkg::KC_SLASH) q_cmd.plain_byte = kute_pkg::BYTE_QMARK;
        else if (!shift && key >= kute_pkg::KC_A && key <= kute_pkg::KC_Z)
            q_cmd.plain_byte = key[7:0] + kute_pkg::CASE_OFFSET;
        else q_cmd.plain_byte = key[7:0];

        q_cmd.acute_byte = (acute_raw != 8'd0) ? acute_raw + adj : 8'd0;
        q_cmd.tilde_byte = (key == kute_pkg::KC_N) ? kute_pkg::SEC_N + adj : 8'd0;
    end

endmodule

[design/kute_queue.sv]
// Short command queue between the front and back ends.
module kute_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kute_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output kute_pkg::cmd_t      head_cmd,
    output kute_pkg::q_status_t status
);

    kute_pkg::cmd_t                entry_reg [kute_pkg::QUEUE_DEPTH];
    logic [kute_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [kute_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [kute_pkg::QCNT_W-1:0]   count_reg;
    logic [kute_pkg::QCNT_W-1:0]   count_next;

    assign status.full  = (count_reg == kute_pkg::QCNT_W'(kute_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[design/kute_back.sv]
// Back end: text store, cursor, accent state, write planning and result register.
module kute_back #(
    parameter int STORE_DEPTH = kute_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [kute_pkg::CAP_W-1:0]    cfg_wr_data,
    input  kute_pkg::cmd_t                q_cmd,
    input  kute_pkg::q_status_t           q_status,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    // Only addresses below 256 are ever used, so the store needs no more
    localparam int MEM_DEPTH = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [kute_pkg::CAP_W-1:0] CAP_LIMIT = kute_pkg::CAP_W'(MEM_DEPTH);

    // Position modulo store depth, by conditional subtraction
    function automatic logic [AW-1:0] wrap_addr(input logic [7:0] a);
        logic [8:0] x;
        x = {1'b0, a};
        for (int i = 7; i >= 0; i--) begin
            if ((MEM_DEPTH << i) <= 255) begin
                if (int'(x) >= (MEM_DEPTH << i)) x = x - 9'(MEM_DEPTH << i);
            end
        end
        return AW'(x);
    endfunction

    kute_pkg::back_state_t         state_reg, state_next;
    kute_pkg::cmd_t                cmd_reg;
    kute_pkg::plan_t               plan_reg, plan_next;
    kute_pkg::accent_t             accent_reg, accent_next;
    logic [7:0]                    cursor_reg, cursor_next;
    logic [kute_pkg::CAP_W-1:0]    cap_reg;
    logic [kute_pkg::CAP_W-1:0]    cap;

    logic [7:0]                    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]          valid_reg;
    logic [7:0]                    rd_data_reg;
    logic                          rd_valid_reg;
    logic [AW-1:0]                 rd_addr;

    logic                          out_free;
    logic                          out_load;
    logic                          sel1;
    logic                          res_valid;
    logic                          res_last;
    logic [7:0]                    res_addr;
    logic [7:0]                    res_byte;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;

    logic                          m_tvalid_reg;
    logic [31:0]                   m_tdata_reg;
    logic                          m_tuser_reg;
    logic                          m_tlast_reg;

    logic [8:0]                    c1, c2;
    logic                          room1, room2;
    logic                          tail;
    logic [7:0]                    second;
    logic [7:0]                    cur_p1, cur_m1, cur_m2;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) cap_reg <= kute_pkg::CAP_RESET;
        else if (cfg_wr_en) cap_reg <= cfg_wr_data;
    end

    assign cap = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;

    // Sequencer
    assign q_pop    = (state_reg == kute_pkg::ST_IDLE) && !q_status.empty;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free &&
                      ((state_reg == kute_pkg::ST_OUT0) || (state_reg == kute_pkg::ST_OUT1));

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= kute_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kute_pkg::ST_IDLE: if (!q_status.empty) state_next = kute_pkg::ST_LOOK;
            kute_pkg::ST_LOOK: state_next = kute_pkg::ST_OUT0;
            kute_pkg::ST_OUT0: begin
                if (out_free)
                    state_next = (plan_reg.count == 2'd2) ? kute_pkg::ST_OUT1
                                                          : kute_pkg::ST_IDLE;
            end
            kute_pkg::ST_OUT1: if (out_free) state_next = kute_pkg::ST_IDLE;
            default: state_next = kute_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cmd_reg <= q_cmd;
    end

    // Write planning for the popped command
    assign c1     = {1'b0, cursor_reg} + 9'd1;
    assign c2     = {1'b0, cursor_reg} + 9'd2;
    assign room1  = c1 < cap;
    assign room2  = c2 < cap;
    assign cur_p1 = cursor_reg + 8'd1;
    assign cur_m1 = cursor_reg - 8'd1;
    assign cur_m2 = cursor_reg - 8'd2;
    assign tail   = rd_valid_reg && (rd_data_reg[7:6] == kute_pkg::TAIL_TAG);

    always_comb begin
        if (accent_reg == kute_pkg::ACC_ACUTE) second = cmd_reg.acute_byte;
        else if (accent_reg == kute_pkg::ACC_TILDE) second = cmd_reg.tilde_byte;
        else second = 8'd0;
    end

    always_comb begin
        plan_next   = plan_reg;
        cursor_next = cursor_reg;
        accent_next = accent_reg;
        if (state_reg == kute_pkg::ST_LOOK) begin
            plan_next = '0;
            unique case (cmd_reg.kind)
                kute_pkg::KIND_PRINT: begin
                    if (room1) begin
                        if (accent_reg != kute_pkg::ACC_NONE) begin
                            accent_next = kute_pkg::ACC_NONE;
                            if (room2) begin
                                plan_next.count = 2'd2;
                                plan_next.addr0 = cursor_reg;
                                plan_next.addr1 = cur_p1;
                                if (second != 8'd0) begin
                                    // composed Latin-1 letter
                                    plan_next.byte0 = kute_pkg::LEAD_C3;
                                    plan_next.byte1 = second;
                                    cursor_next = cursor_reg + 8'd2;
                                end
                                // otherwise erase the accent glyph
                            end
                        end else if (cmd_reg.alt) begin
                            if (room2) begin
                                plan_next.addr0 = cursor_reg;
                                plan_next.addr1 = cur_p1;
                                case (cmd_reg.alt_op)
                                    kute_pkg::ALT_ACUTE: begin
                                        plan_next.count = 2'd2;
                                        plan_next.byte0 = kute_pkg::LEAD_C2;
                                        plan_next.byte1 = kute_pkg::ACUTE_GLYPH;
                                        accent_next = kute_pkg::ACC_ACUTE;
                                    end
                                    kute_pkg::ALT_TILDE: begin
                                        plan_next.count = 2'd2;
                                        plan_next.byte0 = kute_pkg::LEAD_CB;
                                        plan_next.byte1 = kute_pkg::TILDE_GLYPH;
                                        accent_next = kute_pkg::ACC_TILDE;
                                    end
                                    kute_pkg::ALT_INVQ: begin
                                        plan_next.count = 2'd2;
                                        plan_next.byte0 = kute_pkg::LEAD_C2;
                                        plan_next.byte1 = kute_pkg::INV_QMARK;
                                        cursor_next = cursor_reg + 8'd2;
                                    end
                                    default: begin
                                        plan_next.addr0 = 8'd0;
                                        plan_next.addr1 = 8'd0;
                                    end
                                endcase
                            end
                        end else begin
                            plan_next.count = 2'd1;
                            plan_next.addr0 = cursor_reg;
                            plan_next.byte0 = cmd_reg.plain_byte;
                            cursor_next = cur_p1;
                        end
                    end
                end
                kute_pkg::KIND_BKSP: begin
                    if (accent_reg != kute_pkg::ACC_NONE) begin
                        // erase the pending glyph, cursor stays
                        plan_next.count = room1 ? 2'd2 : 2'd1;
                        plan_next.addr0 = cursor_reg;
                        plan_next.addr1 = room1 ? cur_p1 : 8'd0;
                        accent_next = kute_pkg::ACC_NONE;
                    end else if (cursor_reg == 8'd0) begin
                        plan_next.count = 2'd1;
                    end else if (cursor_reg >= 8'd2 && tail) begin
                        plan_next.count = 2'd2;
                        plan_next.addr0 = cur_m1;
                        plan_next.addr1 = cur_m2;
                        cursor_next = cur_m2;
                    end else begin
                        plan_next.count = 2'd1;
                        plan_next.addr0 = cur_m1;
                        cursor_next = cur_m1;
                    end
                end
                kute_pkg::KIND_NOP: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= 8'd0;
            accent_reg <= kute_pkg::ACC_NONE;
        end else begin
            cursor_reg <= cursor_next;
            accent_reg <= accent_next;
        end
    end

    always_ff @(posedge aclk) begin
        plan_reg <= plan_next;
    end

    // Text store: read at pop, written as each result goes out
    assign rd_addr = wrap_addr(cur_m1);
    assign wr_en   = out_load && res_valid;
    assign wr_addr = wrap_addr(res_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= res_byte;
        if (q_pop) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) valid_reg[wr_addr] <= 1'b1;
            if (q_pop) rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Result selection
    assign sel1      = (state_reg == kute_pkg::ST_OUT1);
    assign res_valid = sel1 || (plan_reg.count != 2'd0);
    assign res_last  = sel1 || (plan_reg.count != 2'd2);
    assign res_addr  = sel1 ? plan_reg.addr1 : plan_reg.addr0;
    assign res_byte  = sel1 ? plan_reg.byte1 : plan_reg.byte0;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (out_load) m_tvalid_reg <= 1'b1;
        else if (m_tready) m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'd0, accent_reg, cursor_reg, res_byte, res_addr};
            m_tuser_reg <= res_valid;
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[design/key_to_utf8_text_entry_core.sv]
// Top level of the key press to UTF-8 text entry block.
//
// Input stream (s_*): one request per key press, key number in s_tdata[8:0],
// shift in s_tuser[0], alt in s_tuser[1]. Output stream (m_*): one or two
// results per press, each reporting a store write (m_tuser high) or none,
// with the cursor and pending accent after the press; m_tlast marks the
// final result of a press.
// Configuration: cfg_wr_en/cfg_wr_data write text_capacity at any edge;
// write only while no press is in flight.
// The back end sequencer pops a press and reads the store, then plans its
// writes, then loads each result into the output register (OUT0, then OUT1
// for a second result); it pops the next press only once back in idle.
// A two-entry command queue takes requests while the back end is busy or the
// receiver stalls; s_tready drops only when that queue is full. A stalled
// result holds in the output register and the sequencer waits on it.
// Reset: cursor zero, no accent, capacity 256; per-entry valid bits make the
// whole store read as zero at once, so requests are taken from the first
// cycle after reset.
module key_to_utf8_text_entry_core #(
    parameter int STORE_DEPTH = kute_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [kute_pkg::CAP_W-1:0] cfg_wr_data,   // text_capacity
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,       // [8:0] key number
    input  logic [1:0]                 s_tuser,       // [0] shift_held, [1] alt_held
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] write_address, [15:8] write_byte, [23:16] cursor_after, [25:24] accent_after
    output logic [31:0]                m_tdata,
    output logic                       m_tuser,       // [0] write_valid
    output logic                       m_tlast        // last_result
);

    kute_pkg::q_status_t q_status;
    kute_pkg::cmd_t      push_cmd;
    kute_pkg::cmd_t      head_cmd;
    logic                q_push;
    logic                q_pop;

    kute_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    kute_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    kute_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_cmd       (head_cmd),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // The back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    // A result without a write is always the only result of its press
    a_nowrite_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("no-write result not marked last");

    // Accent code stays in range
    a_accent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:24] != 2'b11))
        else $error("accent code out of range");

    // A first result that is not last is followed by a second write result
    a_pair_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || m_tuser))
        else $error("second result of a press carries no write");
`endif

endmodule

[verif/tb.sv]
// Testbench for key_to_utf8_text_entry_core: shadow text store, stream driver and result checker.
`timescale 1ns / 1ps

module tb;

    // Keys used by the directed requests that the package does not name
    localparam logic [8:0] KC_B        = 9'd66;
    localparam logic [8:0] KC_Q        = 9'd81;
    localparam logic [8:0] KC_UNMAPPED = 9'd258;

    // Receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [8:0] kp_code;
        logic       kp_shift;
        logic       kp_alt;
    } key_press_t;

    typedef struct packed {
        logic       written;
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] cursor;
        logic [1:0] accent;
        logic       last;
    } text_write_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [8:0]  cfg_wr_data = 9'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // [8:0] key number
    logic [1:0]  s_tuser = 2'd0;    // [0] shift_held, [1] alt_held
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] addr, [15:8] byte, [23:16] cursor, [25:24] accent
    logic        m_tuser;           // [0] write_valid
    logic        m_tlast;

    // Shadow copy of the block state
    logic [7:0]        shadow_store [256] = '{default: 8'd0};
    int unsigned       shadow_cursor = 0;
    kute_pkg::accent_t shadow_accent = kute_pkg::ACC_NONE;
    logic [8:0]        shadow_cap = kute_pkg::CAP_RESET;

    // Writes produced by the key press being predicted
    logic [7:0]  press_addr [2];
    logic [7:0]  press_data [2];
    int          press_count;

    key_press_t  key_queue [$];
    text_write_t expected_writes [$];
    int          keys_queued = 0;
    int          keys_taken = 0;
    int          fail_count = 0;

    // Driver and receiver controls
    logic        req_fire = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          dense_tx = 1'b0;
    int          rx_mode = RX_ALWAYS;
    bit          hold_ask = 1'b0;
    int          hold_left = 0;
    int unsigned rx_tick = 0;

    logic [8:0]  accent_keys [6] = '{kute_pkg::KC_A, kute_pkg::KC_E, kute_pkg::KC_I,
                                     kute_pkg::KC_O, kute_pkg::KC_U, kute_pkg::KC_N};

    // Random phase settings
    logic [8:0]  phase_cap   [10] = '{9'd511, 9'd256, 9'd3, 9'd300, 9'd1,
                                      9'd2, 9'd0, 9'd256, 9'd0, 9'd0};
    int          phase_items [10] = '{200, 150, 40, 150, 30, 40, 120, 100, 20, 60};
    int          phase_bksp  [10] = '{15, 20, 45, 15, 50, 45, 25, 10, 60, 25};

    key_to_utf8_text_entry_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Printable key set
    function automatic logic key_prints(input logic [8:0] k);
        return (k == kute_pkg::KC_SPACE) || (k == kute_pkg::KC_QUOTE) ||
               (k == kute_pkg::KC_SEMI) || (k == kute_pkg::KC_EQUALS) ||
               (k == kute_pkg::KC_BACKTICK) ||
               (k >= kute_pkg::KC_COMMA && k <= kute_pkg::KC_DIGIT9) ||
               (k >= kute_pkg::KC_A && k <= kute_pkg::KC_RBRACKET);
    endfunction

    task automatic store_byte(input int unsigned addr, input logic [7:0] b);
        shadow_store[addr % 256] = b;
        if (press_count < 2) begin
            press_addr[press_count] = 8'(addr % 256);
            press_data[press_count] = b;
            press_count++;
        end
    endtask

    task automatic erase_glyph(input int unsigned lim);
        store_byte(shadow_cursor, 8'd0);
        if (shadow_cursor + 1 < lim) store_byte(shadow_cursor + 1, 8'd0);
        shadow_accent = kute_pkg::ACC_NONE;
    endtask

    // Applies one key press to the shadow state and queues the writes it reports
    task automatic press_key(input logic [8:0] key, input logic shift, input logic alt);
        int unsigned lim;
        logic [7:0]  second;
        text_write_t res;
        int          i;
        lim = (shadow_cap > 9'd256) ? 256 : shadow_cap;
        press_count = 0;
        if (key_prints(key)) begin
            if (shadow_cursor + 1 < lim) begin
                if (shadow_accent != kute_pkg::ACC_NONE) begin
                    // dead key pending: compose or drop the glyph
                    if (shadow_cursor + 2 < lim) begin
                        second = 8'd0;
                        if (shadow_accent == kute_pkg::ACC_ACUTE) begin
                            case (key)
                                kute_pkg::KC_A: second = kute_pkg::SEC_A;
                                kute_pkg::KC_E: second = kute_pkg::SEC_E;
                                kute_pkg::KC_I: second = kute_pkg::SEC_I;
                                kute_pkg::KC_O: second = kute_pkg::SEC_O;
                                kute_pkg::KC_U: second = kute_pkg::SEC_U;
                                default:        second = 8'd0;
                            endcase
                        end else if (key == kute_pkg::KC_N) begin
                            second = kute_pkg::SEC_N;
                        end
                        if (second != 8'd0) begin
                            if (!shift) second = second + kute_pkg::CASE_OFFSET;
                            store_byte(shadow_cursor, kute_pkg::LEAD_C3);
                            store_byte(shadow_cursor + 1, second);
                            shadow_cursor += 2;
                        end else begin
                            erase_glyph(lim);
                        end
                    end
                    shadow_accent = kute_pkg::ACC_NONE;
                end else if (alt) begin
                    if (shadow_cursor + 2 < lim) begin
                        if (key == kute_pkg::KC_E) begin
                            store_byte(shadow_cursor, kute_pkg::LEAD_C2);
                            store_byte(shadow_cursor + 1, kute_pkg::ACUTE_GLYPH);
                            shadow_accent = kute_pkg::ACC_ACUTE;
                        end else if (key == kute_pkg::KC_N) begin
                            store_byte(shadow_cursor, kute_pkg::LEAD_CB);
                            store_byte(shadow_cursor + 1, kute_pkg::TILDE_GLYPH);
                            shadow_accent = kute_pkg::ACC_TILDE;
                        end else if (key == kute_pkg::KC_SLASH && shift) begin
                            store_byte(shadow_cursor, kute_pkg::LEAD_C2);
                            store_byte(shadow_cursor + 1, kute_pkg::INV_QMARK);
                            shadow_cursor += 2;
                        end
                    end
                end else if (shift && key == kute_pkg::KC_SLASH) begin
                    store_byte(shadow_cursor, kute_pkg::BYTE_QMARK);
                    shadow_cursor += 1;
                end else begin
                    second = key[7:0];
                    if (!shift && key >= kute_pkg::KC_A && key <= kute_pkg::KC_Z)
                        second = second + kute_pkg::CASE_OFFSET;
                    store_byte(shadow_cursor, second);
                    shadow_cursor += 1;
                end
            end
        end else if (key == kute_pkg::KC_BKSP) begin
            if (shadow_accent != kute_pkg::ACC_NONE) begin
                erase_glyph(lim);
            end else if (shadow_cursor == 0) begin
                store_byte(0, 8'd0);
            end else if (shadow_cursor >= 2 &&
                         shadow_store[(shadow_cursor - 1) % 256][7:6] == kute_pkg::TAIL_TAG)
            begin
                // multibyte character: drop tail then lead
                store_byte(shadow_cursor - 1, 8'd0);
                store_byte(shadow_cursor - 2, 8'd0);
                shadow_cursor -= 2;
            end else begin
                store_byte(shadow_cursor - 1, 8'd0);
                shadow_cursor -= 1;
            end
        end
        shadow_cursor = shadow_cursor % 256;

        res.cursor = 8'(shadow_cursor);
        res.accent = shadow_accent;
        if (press_count == 0) begin
            res.written = 1'b0;
            res.addr = 8'd0;
            res.data = 8'd0;
            res.last = 1'b1;
            expected_writes.push_back(res);
        end else begin
            for (i = 0; i < press_count; i++) begin
                res.written = 1'b1;
                res.addr = press_addr[i];
                res.data = press_data[i];
                res.last = (i == press_count - 1);
                expected_writes.push_back(res);
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
        fail_count++;
    endtask

    // Request acceptance, prediction and result checking
    always @(posedge aclk) begin
        text_write_t want;
        if (aresetn) begin
            if (cfg_wr_en) shadow_cap = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                req_fire = 1'b1;
                keys_taken++;
                press_key(s_tdata[8:0], s_tuser[0], s_tuser[1]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("result with none pending", m_tdata, 0);
                end else begin
                    want = expected_writes.pop_front();
                    if (m_tuser !== want.written)
                        report_mismatch("write_valid", m_tuser, want.written);
                    if (m_tdata[7:0] !== want.addr)
                        report_mismatch("write_address", m_tdata[7:0], want.addr);
                    if (m_tdata[15:8] !== want.data)
                        report_mismatch("write_byte", m_tdata[15:8], want.data);
                    if (m_tdata[23:16] !== want.cursor)
                        report_mismatch("cursor_after", m_tdata[23:16], want.cursor);
                    if (m_tdata[25:24] !== want.accent)
                        report_mismatch("accent_after", m_tdata[25:24], want.accent);
                    if (m_tlast !== want.last)
                        report_mismatch("last_result", m_tlast, want.last);
                end
            end
        end
    end

    // Request driver: bursts of random length with random gaps
    always @(negedge aclk) begin
        key_press_t kp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_fire) begin
            // request still waiting for ready
        end else begin
            req_fire = 1'b0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if (dense_tx || $urandom_range(0, 2) == 0) gap_left = 0;
                else gap_left = $urandom_range(1, 8);
            end
            if (gap_left > 0 || key_queue.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                kp = key_queue.pop_front();
                s_tdata <= {7'd0, kp.kp_code};
                s_tuser <= {kp.kp_alt, kp.kp_shift};
                s_tvalid <= 1'b1;
                burst_left--;
            end
        end
    end

    // Receiver: stall pattern per phase, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_ask && hold_left == 0) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= ((rx_tick % 9) < 4);
            endcase
        end
    end

    task automatic queue_key(input logic [8:0] code, input logic shift, input logic alt);
        key_press_t kp;
        kp.kp_code = code;
        kp.kp_shift = shift;
        kp.kp_alt = alt;
        key_queue.push_back(kp);
        keys_queued++;
    endtask

    function automatic logic [8:0] pick_printable();
        logic [8:0] k;
        do k = 9'($urandom_range(32, 96)); while (!key_prints(k));
        return k;
    endfunction

    // Mostly typing with accent sequences, some backspace and noise
    task automatic queue_random(input int count, input int bksp_pct);
        int         i;
        int         r;
        logic [8:0] k;
        i = 0;
        while (i < count) begin
            r = $urandom_range(0, 99);
            if (r < bksp_pct) begin
                queue_key(kute_pkg::KC_BKSP, 1'($urandom), 1'($urandom));
            end else if (r < bksp_pct + 12) begin
                k = $urandom_range(0, 1) ? kute_pkg::KC_E : kute_pkg::KC_N;
                queue_key(k, 1'($urandom), 1'b1);
                r = $urandom_range(0, 9);
                if (r < 6) k = accent_keys[$urandom_range(0, 5)];
                else if (r < 8) k = pick_printable();
                else k = kute_pkg::KC_BKSP;
                queue_key(k, 1'($urandom), $urandom_range(0, 4) == 0);
                i++;
            end else if (r < bksp_pct + 17) begin
                queue_key(9'($urandom_range(0, 511)), 1'($urandom), 1'($urandom));
            end else if (r < bksp_pct + 22) begin
                k = $urandom_range(0, 1) ? kute_pkg::KC_SLASH : pick_printable();
                queue_key(k, 1'($urandom), 1'b1);
            end else begin
                queue_key(pick_printable(), 1'($urandom), 1'b0);
            end
            i++;
        end
    endtask

    // Wait until every request is taken and every result seen, then let the block drain
    task automatic settle();
        do @(negedge aclk); while (keys_taken != keys_queued || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [8:0] value);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stimulus sequence
    initial begin
        int p;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        rx_mode = RX_RANDOM;

        // Directed: field extremes, every key class and edit case
        queue_key(kute_pkg::KC_BKSP, 1'b0, 1'b0);      // backspace with cursor at start
        queue_key(9'd0, 1'b0, 1'b0);                   // non-printable, all bits low
        queue_key(9'd511, 1'b1, 1'b1);                 // non-printable, all bits high
        queue_key(kute_pkg::KC_SPACE, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_QUOTE, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_COMMA, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_DIGIT9, 1'b1, 1'b0);
        queue_key(kute_pkg::KC_A, 1'b0, 1'b0);         // lowered letter
        queue_key(kute_pkg::KC_Z, 1'b1, 1'b0);         // shifted letter kept
        queue_key(kute_pkg::KC_RBRACKET, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_BACKTICK, 1'b1, 1'b0);
        queue_key(kute_pkg::KC_SLASH, 1'b1, 1'b0);     // question mark
        queue_key(kute_pkg::KC_SLASH, 1'b1, 1'b1);     // inverted question mark
        queue_key(kute_pkg::KC_BKSP, 1'b0, 1'b0);      // over a tail byte
        queue_key(kute_pkg::KC_BKSP, 1'b0, 1'b0);      // over plain ASCII
        queue_key(kute_pkg::KC_E, 1'b0, 1'b1);         // arm acute
        queue_key(kute_pkg::KC_E, 1'b1, 1'b0);         // capital E acute
        queue_key(kute_pkg::KC_N, 1'b0, 1'b1);         // arm tilde
        queue_key(kute_pkg::KC_N, 1'b0, 1'b0);         // small n tilde
        queue_key(kute_pkg::KC_N, 1'b0, 1'b1);
        queue_key(KC_B, 1'b0, 1'b0);                   // no composition: glyph dropped
        queue_key(kute_pkg::KC_E, 1'b0, 1'b1);
        queue_key(kute_pkg::KC_BKSP, 1'b0, 1'b0);      // clears pending accent
        queue_key(KC_Q, 1'b0, 1'b1);                   // unused alt combination
        queue_key(kute_pkg::KC_SLASH, 1'b0, 1'b1);     // alt slash without shift
        queue_key(KC_UNMAPPED, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_E, 1'b0, 1'b1);         // leave acute pending
        settle();

        // Accent pending with room for one byte only: key just clears it
        write_capacity(9'(shadow_cursor + 2));
        queue_key(kute_pkg::KC_A, 1'b0, 1'b0);
        settle();

        // Store full with accent pending: accent stays, backspace erases a short glyph
        write_capacity(9'd256);
        queue_key(kute_pkg::KC_N, 1'b0, 1'b1);
        settle();
        write_capacity(9'(shadow_cursor + 1));
        queue_key(kute_pkg::KC_N, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_BKSP, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_A, 1'b1, 1'b0);
        settle();

        // Zero capacity blocks every printable key
        write_capacity(9'd0);
        queue_key(kute_pkg::KC_A, 1'b0, 1'b0);
        queue_key(kute_pkg::KC_E, 1'b0, 1'b1);
        queue_key(kute_pkg::KC_BKSP, 1'b0, 1'b0);
        settle();

        // Random phases across capacity settings
        for (p = 0; p < 10; p++) begin
            if (p == 6 || p == 9) write_capacity(9'($urandom_range(4, 255)));
            else write_capacity(phase_cap[p]);
            dense_tx = (p == 0);
            if (p == 0) rx_mode = RX_ALWAYS;
            else rx_mode = $urandom_range(RX_RANDOM, RX_PERIODIC);
            queue_random(phase_items[p], phase_bksp[p]);
            if (p == 1 || p == 7) hold_ask = 1'b1;
            settle();
        end

        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
